// ----- rtl/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared widths, register map, result slots and types for the Laplacian
// sharpen block.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // Payload widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int LINE_W  = 2 * PIX_W;

  // Largest pixel value after clamping
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Default for the largest supported image side
  localparam int MAX_SIZE_DEF = 1024;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_SIZE = '0;
  localparam logic [SIZE_W-1:0]    SIZE_RESET     = 11'd512;

  // Result slots, in output order
  localparam int NRES        = 4;
  localparam int RES_INNER   = 0;  // (r-1, c-1)
  localparam int RES_RIGHT   = 1;  // (r-1, c) at the end of a row
  localparam int RES_BOTTOM  = 2;  // (r, c-1) on the bottom row
  localparam int RES_CORNER  = 3;  // (r, c) at the frame end

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // Position of the incoming pixel within the frame
  typedef struct packed {
    logic rg1;    // row >= 1
    logic rg2;    // row >= 2
    logic cg1;    // col >= 1
    logic cg2;    // col >= 2
    logic rlast;  // bottom row
    logic clast;  // last column
  } lsc_flags_t;

  // One result transaction
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } lsc_res_t;

endpackage

// ----- rtl/lsc_line_mem.sv -----
// ----------------------------------------------------------------------------
// lsc_line_mem
// Line store: one synchronous memory holding the two previous rows of each
// column, upper row in the high byte. One read and one write port.
// ----------------------------------------------------------------------------
module lsc_line_mem
  import lsc_pkg::*;
#(
  parameter int DEPTH = MAX_SIZE_DEF,
  parameter int AW    = $clog2(MAX_SIZE_DEF)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [LINE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LINE_W-1:0] wr_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lsc_window.sv -----
// ----------------------------------------------------------------------------
// lsc_window
// 3x3 column-shift window and the sharpen arithmetic for the up to four
// pixels that the newest column completes.
// ----------------------------------------------------------------------------
module lsc_window
  import lsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [PIX_W-1:0] col_up,
  input  logic [PIX_W-1:0] col_mid,
  input  logic [PIX_W-1:0] col_cur,
  input  lsc_flags_t       flags,
  output logic [NRES-1:0]  res_hit,
  output logic [PIX_W-1:0] res_pix [NRES]
);

  // Two stored columns: w1 is c-1, w2 is c (before the shift)
  logic [PIX_W-1:0] w1 [3];
  logic [PIX_W-1:0] w2 [3];
  // View after the shift: v[row][col]
  logic [PIX_W-1:0] v [3][3];

  // centre - (4*centre - neighbours), clamped; neighbours already masked
  function automatic logic [PIX_W-1:0] sharpen(
    input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] u,
    input logic [PIX_W-1:0] d,
    input logic [PIX_W-1:0] l,
    input logic [PIX_W-1:0] r
  );
    logic signed [11:0] s;
    logic [PIX_W-1:0]   y;
    s = $signed(12'(u) + 12'(d) + 12'(l) + 12'(r) - 12'({c, 1'b0}) - 12'(c));
    if (s < 0) begin
      y = '0;
    end else if (s > $signed(12'(PIX_MAX))) begin
      y = PIX_MAX;
    end else begin
      y = s[PIX_W-1:0];
    end
    return y;
  endfunction

  function automatic logic [PIX_W-1:0] keep(input logic en, input logic [PIX_W-1:0] x);
    return en ? x : '0;
  endfunction

  // Advance the window on every transaction that reaches this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        w1[i] <= '0;
        w2[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < 3; i++) begin
        w1[i] <= w2[i];
      end
      w2[0] <= col_up;
      w2[1] <= col_mid;
      w2[2] <= col_cur;
    end
  end

  // Form the shifted view
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i][0] = w1[i];
      v[i][1] = w2[i];
    end
    v[0][2] = col_up;
    v[1][2] = col_mid;
    v[2][2] = col_cur;
  end

  // Select which pixels complete and compute them
  always_comb begin
    res_hit[RES_INNER]  = flags.rg1 & flags.cg1;
    res_hit[RES_RIGHT]  = flags.rg1 & flags.clast;
    res_hit[RES_BOTTOM] = flags.rlast & flags.cg1;
    res_hit[RES_CORNER] = flags.rlast & flags.clast;

    res_pix[RES_INNER]  = sharpen(v[1][1], keep(flags.rg2, v[0][1]), v[2][1],
                                  keep(flags.cg2, v[1][0]), v[1][2]);
    res_pix[RES_RIGHT]  = sharpen(v[1][2], keep(flags.rg2, v[0][2]), v[2][2],
                                  keep(flags.cg1, v[1][1]), '0);
    res_pix[RES_BOTTOM] = sharpen(v[2][1], keep(flags.rg1, v[1][1]), '0,
                                  keep(flags.cg2, v[2][0]), v[2][2]);
    res_pix[RES_CORNER] = sharpen(v[2][2], keep(flags.rg1, v[1][2]), '0,
                                  keep(flags.cg1, v[2][1]), '0);
  end

endmodule

// ----- rtl/lsc_out_fifo.sv -----
// ----------------------------------------------------------------------------
// lsc_out_fifo
// Result queue: takes up to four results per cycle in slot order and hands
// out one transaction per cycle on the valid/stall output channel while not stalled.
// ----------------------------------------------------------------------------
module lsc_out_fifo
  import lsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [NRES-1:0]       push,
  input  lsc_res_t              push_data [NRES],
  output logic                  out_valid,
  input  logic                  out_stall,
  output lsc_res_t              out_data,
  output logic [FIFO_CNT_W-1:0] count
);

  lsc_res_t              mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W-1:0] pos [NRES];
  logic [2:0]            n_push;
  logic                  pop;

  // Compact the pushed slots onto consecutive entries
  always_comb begin
    logic [2:0] off;
    off = '0;
    for (int j = 0; j < NRES; j++) begin
      pos[j] = FIFO_PTR_W'(wr_ptr + FIFO_PTR_W'(off));
      off    = off + 3'(push[j]);
    end
    n_push = off;
  end

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid & ~out_stall;

  // Store pushed results
  always_ff @(posedge clk) begin
    for (int j = 0; j < NRES; j++) begin
      if (push[j]) begin
        mem[pos[j]] <= push_data[j];
      end
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_PTR_W'(wr_ptr + FIFO_PTR_W'(n_push));
      rd_ptr <= FIFO_PTR_W'(rd_ptr + FIFO_PTR_W'(pop));
      count  <= FIFO_CNT_W'(count + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop));
    end
  end

endmodule

// ----- rtl/laplacian_subtract_clamp.sv -----
// ----------------------------------------------------------------------------
// laplacian_subtract_clamp
// Streaming 4-neighbour sharpen filter over a square image with line stores.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per clock while the result
// queue has room; each result (original minus 4-neighbour Laplacian, clamped
// to 0..255) leaves with its row and column through the read stage and the
// result queue after the transaction that completes its neighbourhood. On
// the bottom row each pixel after the first completes two or more results
// and the single output port drains one per clock while not stalled, so the
// input is throttled there. Both previous rows live in one line-store
// memory that is read and written back once per pixel, with forwarding for
// a back-to-back access to the same column. Writing image_size restarts the
// frame; do it only while no results are outstanding.
// ----------------------------------------------------------------------------
module laplacian_subtract_clamp
  import lsc_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // Pixel input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   pixel_in,
  // Result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   pixel_out,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               frame_last
);

  localparam int CW = $clog2(MAX_SIZE);

  // Last valid index for a programmed size: zero acts as one, large clamps
  function automatic logic [CW-1:0] eff_last(input logic [SIZE_W-1:0] sz);
    logic [31:0] s;
    s = 32'(sz);
    if (s == 32'd0) begin
      return '0;
    end else if (s > 32'(MAX_SIZE)) begin
      return CW'(MAX_SIZE - 1);
    end else begin
      return CW'(s - 32'd1);
    end
  endfunction

  logic [SIZE_W-1:0]     image_size;
  logic [CW-1:0]         last_idx;
  logic [CW-1:0]         row;
  logic [CW-1:0]         col;
  logic                  cfg_wr;
  logic                  in_acc;
  lsc_flags_t            flags;
  logic [2:0]            n_res;

  logic                  s1_valid;
  logic [PIX_W-1:0]      s1_pix;
  logic [CW-1:0]         s1_row;
  logic [CW-1:0]         s1_col;
  lsc_flags_t            s1_flags;
  logic [2:0]            s1_cnt;
  logic                  s1_fwd;
  logic [LINE_W-1:0]     fwd_data;

  logic [LINE_W-1:0]     rd_data;
  logic [LINE_W-1:0]     line_col;
  logic [NRES-1:0]       res_hit;
  logic [PIX_W-1:0]      res_pix [NRES];
  lsc_res_t              res [NRES];
  lsc_res_t              head;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // Configuration decode
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready
                & (paddr[PADDR_W-1:2] == REG_IMAGE_SIZE);

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_IMAGE_SIZE: prdata = DATA_W'(image_size);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_RESET;
      last_idx   <= eff_last(SIZE_RESET);
    end else if (cfg_wr) begin
      image_size <= pwdata[SIZE_W-1:0];
      last_idx   <= eff_last(pwdata[SIZE_W-1:0]);
    end
  end

  // Hold input while the queue might not absorb this and the pending item
  assign in_stall = (5'(fifo_count) + 5'(s1_cnt)) > 5'(FIFO_DEPTH - NRES);
  assign in_acc   = in_valid & ~in_stall;

  // Position flags of the incoming pixel
  always_comb begin
    flags.rg1   = (row != '0);
    flags.rg2   = (row > CW'(1));
    flags.cg1   = (col != '0);
    flags.cg2   = (col > CW'(1));
    flags.rlast = (row == last_idx);
    flags.clast = (col == last_idx);
    n_res = 3'(flags.rg1 & flags.cg1) + 3'(flags.rg1 & flags.clast)
          + 3'(flags.rlast & flags.cg1) + 3'(flags.rlast & flags.clast);
  end

  // Advance raster counters; a size write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cfg_wr) begin
      row <= '0;
      col <= '0;
    end else if (in_acc) begin
      if (flags.clast) begin
        col <= '0;
        row <= flags.rlast ? '0 : CW'(row + CW'(1));
      end else begin
        col <= CW'(col + CW'(1));
      end
    end
  end

  // Read stage: capture the pixel while the line store is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_cnt   <= '0;
    end else begin
      s1_valid <= in_acc;
      s1_cnt   <= in_acc ? n_res : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix   <= pixel_in;
      s1_row   <= row;
      s1_col   <= col;
      s1_flags <= flags;
      s1_fwd   <= s1_valid && (col == s1_col);
      fwd_data <= {line_col[PIX_W-1:0], s1_pix};
    end
  end

  lsc_line_mem #(
    .DEPTH (MAX_SIZE),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({line_col[PIX_W-1:0], s1_pix})
  );

  // Forward a write to the same column that the memory read missed
  assign line_col = s1_fwd ? fwd_data : rd_data;

  lsc_window u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_valid),
    .col_up  (line_col[LINE_W-1:PIX_W]),
    .col_mid (line_col[PIX_W-1:0]),
    .col_cur (s1_pix),
    .flags   (s1_flags),
    .res_hit (res_hit),
    .res_pix (res_pix)
  );

  // Attach coordinates to each completed pixel
  always_comb begin
    res[RES_INNER].row  = COORD_W'(CW'(s1_row - CW'(1)));
    res[RES_INNER].col  = COORD_W'(CW'(s1_col - CW'(1)));
    res[RES_INNER].last = 1'b0;
    res[RES_RIGHT].row  = COORD_W'(CW'(s1_row - CW'(1)));
    res[RES_RIGHT].col  = COORD_W'(s1_col);
    res[RES_RIGHT].last = 1'b0;
    res[RES_BOTTOM].row = COORD_W'(s1_row);
    res[RES_BOTTOM].col = COORD_W'(CW'(s1_col - CW'(1)));
    res[RES_BOTTOM].last = 1'b0;
    res[RES_CORNER].row = COORD_W'(s1_row);
    res[RES_CORNER].col = COORD_W'(s1_col);
    res[RES_CORNER].last = 1'b1;
    for (int j = 0; j < NRES; j++) begin
      res[j].pix = res_pix[j];
    end
  end

  lsc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_hit & {NRES{s1_valid}}),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head),
    .count     (fifo_count)
  );

  assign pixel_out  = head.pix;
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign frame_last = head.last;

  // Queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Raster counters stay inside the programmed frame
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    (col <= last_idx) && (row <= last_idx))
    else $error("raster counter outside frame");

  // An empty pipeline always takes input
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    (fifo_count == '0) && !s1_valid |-> !in_stall)
    else $error("input held with empty pipeline");

  // The pending count follows the read stage
  a_pending: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> (s1_cnt == 3'd0))
    else $error("pending results without a transaction");

endmodule

// ----- verif/tb_laplacian_subtract_clamp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laplacian_subtract_clamp
// Self-checking bench for the streaming 4-neighbour sharpen filter: a short
// table of directed pixels with hand-computed results, then random frames of
// many sizes, every result matched field by field against a software
// rendition of the filter that tracks line stores, window and position.
// ----------------------------------------------------------------------------
module tb_laplacian_subtract_clamp;
  import lsc_pkg::*;

  localparam int SETTLE    = 8;
  localparam int LIMIT     = 2000;
  localparam int LONG_HOLD = 200;
  localparam int SIDE_MAX  = MAX_SIZE_DEF;

  localparam logic [PADDR_W-1:0] ADDR_IMAGE_SIZE = {REG_IMAGE_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED     = {~REG_IMAGE_SIZE, 2'b00};

  // One directed step: optional register write, then one pixel
  typedef struct packed {
    logic               cfg;
    logic [PADDR_W-1:0] addr;
    logic [DATA_W-1:0]  wdata;
    logic [PIX_W-1:0]   pix;
    logic               typed;   // results listed in hand_results
    logic [2:0]         ntyped;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0]  pwdata    = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   pixel_in  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_last;

  // Filter state as the testbench sees it
  logic [SIZE_W-1:0]  side_reg;
  logic [PIX_W-1:0]   line_up  [SIDE_MAX];
  logic [PIX_W-1:0]   line_mid [SIDE_MAX];
  logic [PIX_W-1:0]   win_px   [9];
  int unsigned        row_pos;
  int unsigned        col_pos;

  lsc_res_t pending_results [$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  bit       hold_off_req = 1'b0;

  // Results that can be read straight off the filter definition
  lsc_res_t hand_results [0:6] = '{
    '{8'd0,   10'd0, 10'd0, 1'b1},
    '{8'd0,   10'd0, 10'd0, 1'b1},
    '{8'd0,   10'd0, 10'd0, 1'b1},
    '{8'd255, 10'd0, 10'd0, 1'b0},
    '{8'd0,   10'd0, 10'd1, 1'b0},
    '{8'd0,   10'd1, 10'd0, 1'b0},
    '{8'd255, 10'd1, 10'd1, 1'b1}
  };

  stim_row_t dir_table [0:19] = '{
    // one-pixel image: every result is the pixel alone, clamped at zero
    '{1'b1, ADDR_IMAGE_SIZE, 32'd1, 8'd0,   1'b1, 3'd1},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b1, 3'd1},
    // a size of zero behaves as one
    '{1'b1, ADDR_IMAGE_SIZE, 32'd0, 8'd200, 1'b1, 3'd1},
    // 2x2 frame: all four results come with the last pixel, both clamps hit
    '{1'b1, ADDR_IMAGE_SIZE, 32'd2, 8'd0,   1'b1, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b1, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b1, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd0,   1'b1, 3'd4},
    // next frame starts after the wrap; a write to an unused register
    // in mid-frame must leave the position alone
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd9,   1'b0, 3'd0},
    '{1'b1, ADDR_UNUSED,     32'd3, 8'd130, 1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd77,  1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b0, 3'd0},
    // 3x3 checkerboard: dark centre with four bright neighbours
    '{1'b1, ADDR_IMAGE_SIZE, 32'd3, 8'd0,   1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd0,   1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd0,   1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd0,   1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd255, 1'b0, 3'd0},
    '{1'b0, ADDR_IMAGE_SIZE, 32'd0, 8'd0,   1'b0, 3'd0}
  };

  laplacian_subtract_clamp uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Side length in effect: zero acts as one, above the maximum clips
  function automatic int unsigned active_side();
    if (side_reg == '0) return 1;
    if (side_reg > SIDE_MAX) return SIDE_MAX;
    return int'(side_reg);
  endfunction

  task automatic clear_model();
    side_reg = SIZE_RESET;
    row_pos  = 0;
    col_pos  = 0;
    for (int k = 0; k < SIDE_MAX; k++) begin
      line_up[k]  = '0;
      line_mid[k] = '0;
    end
    for (int k = 0; k < 9; k++) win_px[k] = '0;
  endtask

  // Original minus Laplacian for window cell (cr,cc), missing neighbours zero
  function automatic logic [PIX_W-1:0] sharpen_at(input int cr, input int cc,
      input bit up, input bit left, input bit right, input bit down);
    int acc;
    acc = 0;
    if (up && cr >= 1) acc += int'(win_px[(cr - 1) * 3 + cc]);
    if (down && cr <= 1) acc += int'(win_px[(cr + 1) * 3 + cc]);
    if (left && cc >= 1) acc += int'(win_px[cr * 3 + cc - 1]);
    if (right && cc <= 1) acc += int'(win_px[cr * 3 + cc + 1]);
    acc -= 3 * int'(win_px[cr * 3 + cc]);
    if (acc < 0) acc = 0;
    if (acc > int'(PIX_MAX)) acc = int'(PIX_MAX);
    return acc[PIX_W-1:0];
  endfunction

  task automatic queue_result(input logic [PIX_W-1:0] pix, input int unsigned r,
                              input int unsigned c, input logic last);
    lsc_res_t res;
    res.pix  = pix;
    res.row  = r[COORD_W-1:0];
    res.col  = c[COORD_W-1:0];
    res.last = last;
    pending_results.push_back(res);
  endtask

  // Advance the filter by one pixel; queue its results when keep is set
  task automatic sharpen_pixel(input logic [PIX_W-1:0] px, input bit keep);
    int unsigned side;
    int unsigned r;
    int unsigned c;
    side = active_side();
    r    = row_pos;
    c    = col_pos;
    if (r >= side) r = 0;
    if (c >= side) c = 0;
    // shift the window left and load the new column
    for (int k = 0; k < 3; k++) begin
      win_px[k * 3]     = win_px[k * 3 + 1];
      win_px[k * 3 + 1] = win_px[k * 3 + 2];
    end
    win_px[2]   = line_up[c];
    win_px[5]   = line_mid[c];
    win_px[8]   = px;
    line_up[c]  = line_mid[c];
    line_mid[c] = px;
    if (keep) begin
      if (r >= 1 && c >= 1)
        queue_result(sharpen_at(1, 1, r >= 2, c >= 2, 1'b1, 1'b1), r - 1, c - 1, 1'b0);
      if (r >= 1 && c == side - 1)
        queue_result(sharpen_at(1, 2, r >= 2, c >= 1, 1'b0, 1'b1), r - 1, c, 1'b0);
      if (r == side - 1 && c >= 1)
        queue_result(sharpen_at(2, 1, r >= 1, c >= 2, 1'b1, 1'b0), r, c - 1, 1'b0);
      if (r == side - 1 && c == side - 1)
        queue_result(sharpen_at(2, 2, r >= 1, c >= 1, 1'b0, 1'b0), r, c, 1'b1);
    end
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // Register bus: setup then access; call at a rising edge
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror an image_size write, and read image_size back
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    reg_write(addr, data);
    if (addr == ADDR_IMAGE_SIZE) begin
      side_reg = data[SIZE_W-1:0];
      row_pos  = 0;
      col_pos  = 0;
    end
    // leave the bus idle between the write and the read-back
    @(posedge clk);
    reg_read(ADDR_IMAGE_SIZE, rd);
    if (rd !== DATA_W'(side_reg))
      report_mismatch($sformatf("image_size reads %0h, want %0h", rd, side_reg));
  endtask

  // Drop valid, drain all results, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one pixel and return at the edge that accepts it
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit keep);
    in_valid <= 1'b1;
    pixel_in <= px;
    do @(posedge clk); while (in_stall);
    sharpen_pixel(px, keep);
  endtask

  // Random sender gap: mostly none or short, now and then long
  task automatic pause_sender(input bit gapless);
    int pick;
    int gap;
    if (gapless) return;
    pick = $urandom_range(0, 99);
    if (pick < 50) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return PIX_MAX;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // One setting of image_size followed by a run of random pixels
  task automatic run_phase(input logic [DATA_W-1:0] data, input int unsigned count,
                           input bit gapless, input bit squeeze);
    wait_idle();
    write_reg(ADDR_IMAGE_SIZE, data);
    if (squeeze) hold_off_req = 1'b1;
    repeat (count) begin
      send_pixel(rand_pixel(), 1'b1);
      pause_sender(gapless);
    end
  endtask

  // Main sequence
  initial begin
    logic [DATA_W-1:0] rd;
    stim_row_t         row;
    int                t;
    int unsigned       side;
    int unsigned       count;
    logic [DATA_W-1:0] data;
    clear_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    reg_read(ADDR_IMAGE_SIZE, rd);
    if (rd !== DATA_W'(SIZE_RESET))
      report_mismatch($sformatf("image_size after reset reads %0h", rd));

    // directed table
    t = 0;
    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.cfg) begin
        wait_idle();
        write_reg(row.addr, row.wdata);
      end
      send_pixel(row.pix, !row.typed);
      if (row.typed)
        for (int k = 0; k < row.ntyped; k++) pending_results.push_back(hand_results[t++]);
      pause_sender(1'b0);
    end

    // dense frames while the receiver holds off for a long stretch
    run_phase(32'd8, 2 * 64, 1'b1, 1'b1);
    // all bits set: clips to the largest side; the top row yields nothing yet
    run_phase('1, 8, 1'b0, 1'b0);

    // small random sizes, whole and partial frames
    repeat (4) begin
      side = $urandom_range(1, 5);
      data = side;
      if ($urandom_range(0, 1) == 1) data |= $urandom() & 32'hFFFF_F800;
      count = side * side + $urandom_range(0, side * side - 1);
      run_phase(data, count, $urandom_range(0, 3) == 0, 1'b0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_laplacian_subtract_clamp: clean");
    end else begin
      $display("tb_laplacian_subtract_clamp: errors");
    end
    $finish;
  end

  // Receiver stall: short and long holds, quiet stretches, one long hold-off
  initial begin
    int pick;
    int len;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 8);
        end else if (pick < 55) begin
          out_stall <= 1'b0;
          len = $urandom_range(30, 80);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 30);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    lsc_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result at (%0d,%0d)", out_row, out_col));
      end else begin
        want = pending_results.pop_front();
        if (pixel_out !== want.pix)
          report_mismatch($sformatf("pixel_out %0h, want %0h at (%0d,%0d)",
                                    pixel_out, want.pix, want.row, want.col));
        if (out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
        if (out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
        if (frame_last !== want.last)
          report_mismatch($sformatf("frame_last %b, want %b at (%0d,%0d)",
                                    frame_last, want.last, want.row, want.col));
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= LIMIT) begin
      $display("tb_laplacian_subtract_clamp: errors");
      $finish;
    end
  end

endmodule
